### hdl/reading_fifo_packetizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the reading FIFO packetizer.
// Each macro places one labeled concurrent assertion, clocked on the rising
// edge and disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef READING_FIFO_PACKETIZER_ASSERT_SVH
`define READING_FIFO_PACKETIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFP_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/rfp_pkg.sv
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared constants, types and helpers of the reading FIFO packetizer.
// ----------------------------------------------------------------------------
`default_nettype none

package rfp_pkg;

  // Number of readings the FIFO holds.
  localparam int unsigned FIFO_DEPTH      = 64;
  // Most readings popped by one packet build.
  localparam int unsigned PACKET_READINGS = 5;

  localparam int unsigned PTR_W     = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W     = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned PKT_CNT_W = $clog2(PACKET_READINGS + 1);

  // Command codes carried by the operation input.
  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_BUILD = 1'b1
  } rfp_op_e;

  typedef logic [PTR_W-1:0] rfp_ptr_t;
  typedef logic [CNT_W-1:0] rfp_cnt_t;

  // Advance a FIFO pointer, wrapping at the last entry.
  function automatic rfp_ptr_t ptr_inc(input rfp_ptr_t ptr);
    rfp_ptr_t nxt;
    if (ptr == PTR_W'(FIFO_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + PTR_W'(1);
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

### hdl/reading_fifo_packetizer.sv
// ----------------------------------------------------------------------------
// reading_fifo_packetizer
// Circular FIFO of sensor readings with a packet builder on the read side.
// ----------------------------------------------------------------------------
// A push is taken when start_i is high and busy_o is low; its single result
// word appears on done_o in the next cycle, and busy_o stays low, so a push can
// be issued every cycle. A build first registers the oldest entry read from
// the reading memory, then emits one word per cycle for up to five readings
// with last_o on the final one, and keeps busy_o high until its last word; a
// build on an empty FIFO returns one empty-packet word in the next cycle. The
// rate of a build is set by the single read port of the memory and its
// registered read. Results are shown for exactly one cycle and the receiver
// cannot hold them off.
// ----------------------------------------------------------------------------
`default_nettype none

module reading_fifo_packetizer
  import rfp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic                operation_i,
  input  wire logic [2:0]          sensor_kind_i,
  input  wire logic signed [31:0]  reading_value_i,
  input  wire logic [31:0]         reading_stamp_i,
  input  wire logic [6:0]          reading_quality_i,
  output logic                     done_o,
  output logic                     accepted_o,
  output logic [15:0]              drop_count_o,
  output logic [CNT_W-1:0]         fill_level_o,
  output logic [15:0]              packet_number_o,
  output logic                     empty_packet_o,
  output logic [2:0]               out_kind_o,
  output logic signed [31:0]       out_value_o,
  output logic [31:0]              out_stamp_o,
  output logic [6:0]               out_quality_o,
  output logic [9:0]               value_byte_sum_o,
  output logic                     last_o
);

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_e;

  // Reading memory: kind, value, timestamp and quality of one reading per entry.
  logic [73:0] reading_mem [FIFO_DEPTH];
  logic [73:0] mem_rd_q;
  logic        wr_en;
  rfp_ptr_t    rd_addr;

  state_e                state_q, state_d;
  rfp_ptr_t              wptr_q, wptr_d;
  rfp_ptr_t              rptr_q, rptr_d;
  rfp_cnt_t              count_q, count_d;
  logic [15:0]           ovf_q, ovf_d;
  logic [15:0]           next_id_q, next_id_d;
  logic [PKT_CNT_W-1:0]  n_q, n_d;

  logic        done_q, done_d;
  logic        acc_q, acc_d;
  logic [15:0] pkt_q, pkt_d;
  logic        empty_q, empty_d;
  logic [2:0]  kind_q, kind_d;
  logic [31:0] value_q, value_d;
  logic [31:0] stamp_q, stamp_d;
  logic [6:0]  qual_q, qual_d;
  logic [9:0]  bsum_q, bsum_d;
  logic        last_q, last_d;

  logic        pop_last;
  logic [2:0]  rd_kind;
  logic [31:0] rd_value;
  logic [31:0] rd_stamp;
  logic [6:0]  rd_qual;

  // Fields of the entry read out of the memory.
  assign rd_kind  = mem_rd_q[73:71];
  assign rd_value = mem_rd_q[70:39];
  assign rd_stamp = mem_rd_q[38:7];
  assign rd_qual  = mem_rd_q[6:0];
  // The last word of a build: packet full or FIFO drained by this pop.
  assign pop_last = (n_q == PKT_CNT_W'(PACKET_READINGS - 1)) ||
                    (count_q == CNT_W'(1));

  // Next-state logic for the command sequencer and the FIFO bookkeeping.
  always_comb begin
    state_d   = state_q;
    wptr_d    = wptr_q;
    rptr_d    = rptr_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    next_id_d = next_id_q;
    n_d       = n_q;
    wr_en     = 1'b0;
    done_d    = 1'b0;
    acc_d     = acc_q;
    pkt_d     = pkt_q;
    empty_d   = empty_q;
    kind_d    = kind_q;
    value_d   = value_q;
    stamp_d   = stamp_q;
    qual_d    = qual_q;
    bsum_d    = bsum_q;
    last_d    = last_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          done_d  = 1'b1;
          last_d  = 1'b1;
          kind_d  = '0;
          value_d = '0;
          stamp_d = '0;
          qual_d  = '0;
          bsum_d  = '0;
          empty_d = 1'b0;
          acc_d   = 1'b0;
          if (rfp_op_e'(operation_i) == OP_PUSH) begin
            pkt_d = '0;
            if (count_q == CNT_W'(FIFO_DEPTH)) begin
              ovf_d = ovf_q + 16'd1;
            end else begin
              wr_en   = 1'b1;
              wptr_d  = ptr_inc(wptr_q);
              count_d = count_q + CNT_W'(1);
              acc_d   = 1'b1;
            end
          end else begin
            pkt_d     = next_id_q;
            next_id_d = next_id_q + 16'd1;
            if (count_q == '0) begin
              empty_d = 1'b1;
            end else begin
              // The memory read of the oldest entry is launched at this edge.
              done_d  = 1'b0;
              state_d = ST_POP;
              n_d     = '0;
            end
          end
        end
      end
      ST_POP: begin
        done_d  = 1'b1;
        kind_d  = rd_kind;
        value_d = rd_value;
        stamp_d = rd_stamp;
        qual_d  = rd_qual;
        bsum_d  = 10'(rd_value[7:0]) + 10'(rd_value[15:8]) +
                  10'(rd_value[23:16]) + 10'(rd_value[31:24]);
        last_d  = pop_last;
        rptr_d  = ptr_inc(rptr_q);
        count_d = count_q - CNT_W'(1);
        if (pop_last) begin
          state_d = ST_IDLE;
        end else begin
          n_d = n_q + PKT_CNT_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Reading the next pointer keeps one pop per cycle flowing.
  assign rd_addr = rptr_d;

  // Reading memory: write on push, registered read every cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      reading_mem[wptr_q] <= {sensor_kind_i, reading_value_i, reading_stamp_i,
                              reading_quality_i};
    end
    mem_rd_q <= reading_mem[rd_addr];
  end

  // Sequencer state, FIFO bookkeeping and the result word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wptr_q    <= '0;
      rptr_q    <= '0;
      count_q   <= '0;
      ovf_q     <= '0;
      next_id_q <= '0;
      n_q       <= '0;
      done_q    <= 1'b0;
      acc_q     <= 1'b0;
      pkt_q     <= '0;
      empty_q   <= 1'b0;
      kind_q    <= '0;
      value_q   <= '0;
      stamp_q   <= '0;
      qual_q    <= '0;
      bsum_q    <= '0;
      last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      wptr_q    <= wptr_d;
      rptr_q    <= rptr_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      next_id_q <= next_id_d;
      n_q       <= n_d;
      done_q    <= done_d;
      acc_q     <= acc_d;
      pkt_q     <= pkt_d;
      empty_q   <= empty_d;
      kind_q    <= kind_d;
      value_q   <= value_d;
      stamp_q   <= stamp_d;
      qual_q    <= qual_d;
      bsum_q    <= bsum_d;
      last_q    <= last_d;
    end
  end

  // Counters are already current when their result word is shown.
  assign busy_o           = (state_q == ST_POP);
  assign done_o           = done_q;
  assign accepted_o       = acc_q;
  assign drop_count_o     = ovf_q;
  assign fill_level_o     = count_q;
  assign packet_number_o  = pkt_q;
  assign empty_packet_o   = empty_q;
  assign out_kind_o       = kind_q;
  assign out_value_o      = $signed(value_q);
  assign out_stamp_o      = stamp_q;
  assign out_quality_o    = qual_q;
  assign value_byte_sum_o = bsum_q;
  assign last_o           = last_q;

endmodule

`default_nettype wire

### hdl/rfp_checker.sv
// ----------------------------------------------------------------------------
// rfp_checker
// Port-level checks of the reading FIFO packetizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "reading_fifo_packetizer_assert.svh"

module rfp_checker
  import rfp_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start_i,
  input wire logic             busy_o,
  input wire logic             operation_i,
  input wire logic             done_o,
  input wire logic             accepted_o,
  input wire logic [CNT_W-1:0] fill_level_o,
  input wire logic             empty_packet_o,
  input wire logic             last_o
);

  logic push_take;
  logic build_take;

  assign push_take  = start_i && !busy_o && (rfp_op_e'(operation_i) == OP_PUSH);
  assign build_take = start_i && !busy_o && (rfp_op_e'(operation_i) == OP_BUILD);

  // A push returns its single word in the next cycle.
  `RFP_ASSERT_NEXT(a_push_word, clk_i, rst_ni, push_take, done_o && last_o && !empty_packet_o, "push word missing")
  // A build either starts popping or returns the empty-packet word at once.
  `RFP_ASSERT_NEXT(a_build_start, clk_i, rst_ni, build_take, busy_o || (done_o && empty_packet_o), "build did not start")
  // Words of one packet follow each other without a gap.
  `RFP_ASSERT_NEXT(a_packet_burst, clk_i, rst_ni, done_o && !last_o, done_o, "gap inside a packet")
  // An empty packet is a single word and leaves the FIFO empty.
  `RFP_ASSERT_SAME(a_empty_packet, clk_i, rst_ni, done_o && empty_packet_o, last_o && (fill_level_o == '0), "bad empty packet")
  // A stored reading leaves at least one entry in the FIFO.
  `RFP_ASSERT_SAME(a_stored_fill, clk_i, rst_ni, done_o && accepted_o, fill_level_o != '0, "stored reading not counted")

endmodule

bind reading_fifo_packetizer rfp_checker u_rfp_checker (.*);

`default_nettype wire

### tb/reading_fifo_packetizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reading_fifo_packetizer_tb
// Self-checking bench for the reading FIFO packetizer. A queue of command
// words (pushes and packet builds) feeds a driver that idles at random. A
// model of the FIFO, the drop counter and the packet id predicts every result
// word when a command is taken. A monitor checks each strobed result word
// against the oldest prediction.
// ----------------------------------------------------------------------------
module reading_fifo_packetizer_tb;
  import rfp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned RANDOM_CMDS = 350;

  // One command word as the driver presents it.
  typedef struct {
    rfp_op_e     op;
    logic [2:0]  kind;
    logic [31:0] value;
    logic [31:0] stamp;
    logic [6:0]  quality;
  } cmd_word_t;

  // One stored reading of the FIFO model.
  typedef struct {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [31:0] stamp;
    logic [6:0]  quality;
  } reading_t;

  // One result word, in the order of the result ports.
  typedef struct packed {
    logic            accepted;
    logic [15:0]     drop_count;
    logic [CNT_W-1:0] fill_level;
    logic [15:0]     packet_number;
    logic            empty_pkt;
    logic [2:0]      kind;
    logic [31:0]     value;
    logic [31:0]     stamp;
    logic [6:0]      quality;
    logic [9:0]      byte_sum;
    logic            is_last;
  } result_word_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic                operation_i;
  logic [2:0]          sensor_kind_i;
  logic signed [31:0]  reading_value_i;
  logic [31:0]         reading_stamp_i;
  logic [6:0]          reading_quality_i;
  logic                done_o;
  logic                accepted_o;
  logic [15:0]         drop_count_o;
  logic [CNT_W-1:0]    fill_level_o;
  logic [15:0]         packet_number_o;
  logic                empty_packet_o;
  logic [2:0]          out_kind_o;
  logic signed [31:0]  out_value_o;
  logic [31:0]         out_stamp_o;
  logic [6:0]          out_quality_o;
  logic [9:0]          value_byte_sum_o;
  logic                last_o;

  reading_fifo_packetizer u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .operation_i       (operation_i),
    .sensor_kind_i     (sensor_kind_i),
    .reading_value_i   (reading_value_i),
    .reading_stamp_i   (reading_stamp_i),
    .reading_quality_i (reading_quality_i),
    .done_o            (done_o),
    .accepted_o        (accepted_o),
    .drop_count_o      (drop_count_o),
    .fill_level_o      (fill_level_o),
    .packet_number_o   (packet_number_o),
    .empty_packet_o    (empty_packet_o),
    .out_kind_o        (out_kind_o),
    .out_value_o       (out_value_o),
    .out_stamp_o       (out_stamp_o),
    .out_quality_o     (out_quality_o),
    .value_byte_sum_o  (value_byte_sum_o),
    .last_o            (last_o)
  );

  // Command words waiting for the driver, and result words still expected.
  cmd_word_t    cmd_queue[$];
  result_word_t expected_results[$];

  // State of the FIFO model.
  reading_t     model_mem[FIFO_DEPTH];
  int unsigned  model_wr_idx;
  int unsigned  model_rd_idx;
  int unsigned  model_held;
  logic [15:0]  model_drops;
  logic [15:0]  model_next_pkt;

  // Driver and monitor bookkeeping.
  cmd_word_t    next_cmd;
  result_word_t seen_word;
  result_word_t want_word;
  bit           word_taken;
  int unsigned  idle_left;
  int unsigned  quiet_left;
  int unsigned  mismatch_count;
  int unsigned  cycle_count;
  int unsigned  random_cmds;
  int unsigned  fill_runs;

  always #2 clk_i = ~clk_i;

  // Sum of the four bytes of a reading value.
  function automatic logic [9:0] value_byte_total(input logic [31:0] v);
    return {2'b00, v[7:0]} + {2'b00, v[15:8]} + {2'b00, v[23:16]} + {2'b00, v[31:24]};
  endfunction

  function automatic string result_text(input result_word_t w);
    string head;
    string tail;
    head = $sformatf("acc=%0d drops=%0d fill=%0d pkt=%0d empty=%0d kind=%0d ",
                     w.accepted, w.drop_count, w.fill_level, w.packet_number,
                     w.empty_pkt, w.kind);
    tail = $sformatf("value=%h stamp=%h qual=%0d bsum=%0d last=%0d",
                     w.value, w.stamp, w.quality, w.byte_sum, w.is_last);
    return {head, tail};
  endfunction

  // Idle cycles before the next command: mostly none or short, a few long,
  // and now and then a stretch of back-to-back commands.
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if (r < 3) begin
      quiet_left = $urandom_range(10, 40);
      return 0;
    end else if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 25);
  endfunction

  // Predict the result words of one taken command and update the FIFO model.
  task automatic predict_fifo_results(input rfp_op_e op, input logic [2:0] kind,
                                      input logic [31:0] value,
                                      input logic [31:0] stamp,
                                      input logic [6:0] quality);
    result_word_t w;
    reading_t     rd;
    int unsigned  n;
    w = '0;
    if (op == OP_PUSH) begin
      if (model_held >= FIFO_DEPTH) begin
        model_drops = model_drops + 16'd1;
      end else begin
        model_mem[model_wr_idx] = '{kind, value, stamp, quality};
        model_wr_idx = (model_wr_idx + 1) % FIFO_DEPTH;
        model_held++;
        w.accepted = 1'b1;
      end
      w.drop_count = model_drops;
      w.fill_level = CNT_W'(model_held);
      w.is_last    = 1'b1;
      expected_results.push_back(w);
    end else begin
      w.packet_number = model_next_pkt;
      w.drop_count    = model_drops;
      model_next_pkt  = model_next_pkt + 16'd1;
      if (model_held == 0) begin
        w.empty_pkt = 1'b1;
        w.is_last   = 1'b1;
        expected_results.push_back(w);
      end else begin
        n = 0;
        while (n < PACKET_READINGS && model_held > 0) begin
          rd = model_mem[model_rd_idx];
          model_rd_idx = (model_rd_idx + 1) % FIFO_DEPTH;
          model_held--;
          w.fill_level = CNT_W'(model_held);
          w.kind       = rd.kind;
          w.value      = rd.value;
          w.stamp      = rd.stamp;
          w.quality    = rd.quality;
          w.byte_sum   = value_byte_total(rd.value);
          w.is_last    = (n + 1 == PACKET_READINGS) || (model_held == 0);
          expected_results.push_back(w);
          n++;
        end
      end
    end
  endtask

  task automatic add_push(input logic [2:0] kind, input logic [31:0] value,
                          input logic [31:0] stamp, input logic [6:0] quality);
    cmd_queue.push_back('{OP_PUSH, kind, value, stamp, quality});
  endtask

  // A build carries noise on the reading fields, which the block ignores.
  task automatic add_build();
    cmd_queue.push_back('{OP_BUILD, 3'($urandom), $urandom, $urandom, 7'($urandom)});
  endtask

  // A push with random content, now and then an extreme value or an
  // out-of-range kind or quality.
  task automatic add_random_push();
    logic [2:0]  kind;
    logic [31:0] value;
    logic [6:0]  quality;
    kind    = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 4))
                                           : 3'($urandom_range(5, 7));
    quality = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(0, 100))
                                           : 7'($urandom_range(101, 127));
    case ($urandom_range(0, 11))
      0: value = 32'h8000_0000;
      1: value = 32'h7FFF_FFFF;
      2: value = 32'hFFFF_FFFF;
      3: value = 32'h0000_0000;
      default: value = $urandom;
    endcase
    add_push(kind, value, $urandom, quality);
  endtask

  // Driver: present the next command word at the falling edge, hold it until
  // taken, then idle for a random number of cycles.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!start_i || word_taken) begin
        word_taken = 1'b0;
        if (idle_left > 0) begin
          start_i <= 1'b0;
          idle_left--;
        end else if (cmd_queue.size() > 0) begin
          next_cmd = cmd_queue.pop_front();
          operation_i       <= next_cmd.op;
          sensor_kind_i     <= next_cmd.kind;
          reading_value_i   <= next_cmd.value;
          reading_stamp_i   <= next_cmd.stamp;
          reading_quality_i <= next_cmd.quality;
          start_i           <= 1'b1;
          idle_left = pick_idle();
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check strobed result words first, then model a taken command.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        seen_word = '{accepted_o, drop_count_o, fill_level_o, packet_number_o,
                      empty_packet_o, out_kind_o, out_value_o, out_stamp_o,
                      out_quality_o, value_byte_sum_o, last_o};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("cycle %0d: unexpected result word %s", cycle_count,
                     result_text(seen_word));
          end
        end else begin
          want_word = expected_results.pop_front();
          if (seen_word !== want_word) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("cycle %0d: result word mismatch", cycle_count);
              $display("  expected %s", result_text(want_word));
              $display("  actual   %s", result_text(seen_word));
            end
          end
        end
      end
      if (start_i && !busy_o) begin
        predict_fifo_results(rfp_op_e'(operation_i), sensor_kind_i, reading_value_i,
                             reading_stamp_i, reading_quality_i);
        word_taken = 1'b1;
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    start_i           = 1'b0;
    operation_i       = OP_PUSH;
    sensor_kind_i     = '0;
    reading_value_i   = '0;
    reading_stamp_i   = '0;
    reading_quality_i = '0;
    model_wr_idx      = 0;
    model_rd_idx      = 0;
    model_held        = 0;
    model_drops       = '0;
    model_next_pkt    = '0;
    word_taken        = 1'b0;
    idle_left         = 0;
    quiet_left        = 0;
    mismatch_count    = 0;
    cycle_count       = 0;
    random_cmds       = 0;
    fill_runs         = 0;

    // Directed part: empty build, extreme fields, out-of-range kind and
    // quality, a full packet with leftovers, a short packet and a partial one.
    add_build();
    add_push(3'd0, 32'h8000_0000, 32'h0000_0000, 7'd0);
    add_push(3'd4, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 7'd100);
    add_push(3'd7, 32'hFFFF_FFFF, 32'h1234_5678, 7'd127);
    add_push(3'd5, 32'h0000_0000, 32'hA5A5_5A5A, 7'd101);
    add_push(3'd6, 32'h0000_0001, 32'h0000_0001, 7'd50);
    add_push(3'd1, 32'h1234_5678, 32'h8000_0000, 7'd1);
    add_build();
    add_build();
    add_build();
    add_push(3'd2, 32'hFFFF_FC18, 32'h0000_03E8, 7'd99);
    add_push(3'd3, 32'h00FF_00FF, 32'h7FFF_FFFF, 7'd64);
    add_random_push();
    add_build();
    add_random_push();
    add_random_push();
    add_build();
    add_build();

    // Random part: bursts of pushes and builds, with runs that fill the FIFO
    // past full so that readings get dropped.
    while (random_cmds < RANDOM_CMDS) begin
      if ((fill_runs == 0 && random_cmds >= 120) ||
          (fill_runs < 3 && $urandom_range(0, 99) < 4)) begin
        fill_runs++;
        repeat ($urandom_range(64, 74)) begin
          add_random_push();
          random_cmds++;
        end
      end else if ($urandom_range(0, 99) < 52) begin
        repeat ($urandom_range(1, 10)) begin
          add_random_push();
          random_cmds++;
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          add_build();
          random_cmds++;
        end
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_queue.size() > 0 || start_i || expected_results.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (12) @(posedge clk_i);

    if (expected_results.size() > 0) begin
      $display("%0d result words never arrived", expected_results.size());
      mismatch_count += expected_results.size();
    end

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
